// ----- sv/swm_pkg.sv -----
`timescale 1ns / 1ps

package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_W     = 32;
    localparam int MEDIAN_W     = SAMPLE_W + 1;
    localparam int WIN_W        = 7;
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int OUT_TDATA_W  = ((MEDIAN_W + 7) / 8) * 8;
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);

    typedef struct packed {
        logic [SAMPLE_W-1:0] x;
        logic [SAMPLE_W-1:0] v_old;
        logic                del;
        logic                clr;
    } cell_bcast_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] val;
        logic                vld;
        logic                le;
    } cell_nb_t;

endpackage

// ----- sv/swm_cell.sv -----
`timescale 1ns / 1ps

module swm_cell
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wipe,
    input  logic                en,
    input  cell_bcast_t         bc,
    input  logic [SAMPLE_W-1:0] up_val,
    input  logic                up_vld,
    input  cell_nb_t            lo_nb,
    output cell_nb_t            nb,
    output logic [SAMPLE_W-1:0] s_val,
    output logic                s_vld
);

    logic [SAMPLE_W-1:0] val_reg;
    logic [SAMPLE_W-1:0] val_next;
    logic                vld_reg;
    logic                vld_next;
    logic                vld_cur;
    logic                up_vld_cur;
    logic                lt_old;
    logic                shift;

    // Removing the oldest sample shifts every entry at or above it down by one.
    // The new sample then goes in front of the first entry greater than it.
    always_comb
    begin
        vld_cur    = vld_reg & ~bc.clr;
        up_vld_cur = up_vld & ~bc.clr;
        lt_old     = vld_cur && ($signed(val_reg) < $signed(bc.v_old));
        shift      = bc.del && !lt_old;
        nb.val     = shift ? up_val : val_reg;
        nb.vld     = shift ? up_vld_cur : vld_cur;
        nb.le      = nb.vld && ($signed(nb.val) <= $signed(bc.x));
        priority if (nb.le)
        begin
            val_next = nb.val;
            vld_next = 1'b1;
        end
        else if (lo_nb.le)
        begin
            val_next = bc.x;
            vld_next = 1'b1;
        end
        else
        begin
            val_next = lo_nb.val;
            vld_next = lo_nb.vld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (wipe)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
        end
    end

    assign s_val = val_reg;
    assign s_vld = vld_reg;

endmodule

// ----- sv/sliding_window_median_unit.sv -----
`timescale 1ns / 1ps

// Channel   Direction  tdata                          tuser
// s_axis    in         [31:0] sample (signed)         [0] start_req
// m_axis    out        [32:0] median_x2 (signed)      none
// cfg       in         cfg_wdata[6:0] window_size     none
//
// Each sample beat is sorted into the cell row in the cycle it is accepted.
// The median is taken from the cells once the result register is free, so a beat is taken
// every cycle while m_axis is ready; one result register sets that pace.
// Reset empties the window and sets the window size to three.
// While a result beat waits on m_axis_tready, one more sample beat that fills the
// window is taken and held, and s_axis_tready stays low until the waiting beat leaves.

module sliding_window_median_unit
    import swm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [31:0] sample
    input  logic                   s_axis_tuser,   // [0] start_req
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [32:0] median_x2, rest zero
    input  logic                   cfg_we,
    input  logic [WIN_W-1:0]       cfg_wdata
);

    logic [WIN_W-1:0]    win_reg;
    logic [WIN_W-1:0]    fill_reg;
    logic [WIN_W-1:0]    fill_next;
    logic [WIN_W-1:0]    fill_base;
    logic [WIN_W-1:0]    weff;
    logic                pend_reg;
    logic                pend_next;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [MEDIAN_W-1:0] out_reg;
    logic                out_free;
    logic                accept;
    logic [SAMPLE_W-1:0] line_reg [MAX_WINDOW];
    logic [IDX_W-1:0]    old_idx;
    logic [IDX_W-1:0]    hi_idx;
    logic [IDX_W-1:0]    lo_idx;
    logic [SAMPLE_W-1:0] hi_val;
    logic [SAMPLE_W-1:0] lo_val;
    cell_bcast_t         bc;
    cell_nb_t            nb [MAX_WINDOW];
    logic [SAMPLE_W-1:0] s_val [MAX_WINDOW];
    logic                s_vld [MAX_WINDOW];

    always_comb
    begin
        priority if (win_reg == '0)
        begin
            weff = WIN_W'(1);
        end
        else if (win_reg > WIN_W'(MAX_WINDOW))
        begin
            weff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            weff = win_reg;
        end
    end

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !pend_reg || out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign old_idx = IDX_W'(weff - WIN_W'(1));
    assign hi_idx  = IDX_W'(weff >> 1);
    assign lo_idx  = weff[0] ? hi_idx : IDX_W'(hi_idx - IDX_W'(1));
    assign hi_val  = s_val[hi_idx];
    assign lo_val  = s_val[lo_idx];

    always_comb
    begin
        fill_base = s_axis_tuser ? '0 : fill_reg;
        bc.x      = s_axis_tdata;
        bc.v_old  = line_reg[0];
        bc.clr    = s_axis_tuser;
        bc.del    = (fill_base == weff);
        fill_next = bc.del ? fill_base : WIN_W'(fill_base + WIN_W'(1));
    end

    always_comb
    begin
        pend_next    = pend_reg;
        out_vld_next = out_vld_reg;
        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        if (pend_reg && out_free)
        begin
            pend_next    = 1'b0;
            out_vld_next = 1'b1;
        end
        if (accept)
        begin
            pend_next = (fill_next == weff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg     <= WINDOW_RESET;
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            pend_reg    <= pend_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                win_reg  <= cfg_wdata;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end
        end
    end

    // A new sample enters the delay line at the window's far end and moves one
    // stage down per beat, so the sample leaving the window is always at stage zero.
    always_ff @(posedge clk)
    begin
        if (pend_reg && out_free)
        begin
            out_reg <= MEDIAN_W'($signed(lo_val)) + MEDIAN_W'($signed(hi_val));
        end
        if (accept)
        begin
            for (int j = 0; j < MAX_WINDOW - 1; j++)
            begin
                line_reg[j] <= (IDX_W'(j) == old_idx) ? s_axis_tdata : line_reg[j+1];
            end
            line_reg[MAX_WINDOW-1] <= s_axis_tdata;
        end
    end

    genvar i;
    generate
        for (i = 0; i < MAX_WINDOW; i++)
        begin : g_cell
            cell_nb_t            lo_nb;
            logic [SAMPLE_W-1:0] up_val;
            logic                up_vld;

            if (i == 0)
            begin : g_first
                assign lo_nb = '{val: '0, vld: 1'b0, le: 1'b1};
            end
            else
            begin : g_mid
                assign lo_nb = nb[i-1];
            end

            if (i == MAX_WINDOW - 1)
            begin : g_last
                assign up_val = '0;
                assign up_vld = 1'b0;
            end
            else
            begin : g_up
                assign up_val = s_val[i+1];
                assign up_vld = s_vld[i+1];
            end

            swm_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .wipe   (cfg_we),
                .en     (accept),
                .bc     (bc),
                .up_val (up_val),
                .up_vld (up_vld),
                .lo_nb  (lo_nb),
                .nb     (nb[i]),
                .s_val  (s_val[i]),
                .s_vld  (s_vld[i])
            );
        end
    endgenerate

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - MEDIAN_W){1'b0}}, out_reg};

endmodule

// ----- bench/sliding_window_median_unit_tb.sv -----
`timescale 1ns / 1ps

module sliding_window_median_unit_tb;
    import swm_pkg::*;

    localparam int SETTLE_CYCLES = 6;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_SLOW
    } ready_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we = 1'b0;
    logic [WIN_W-1:0]       cfg_wdata = '0;

    logic signed [MEDIAN_W-1:0] median_q[$];
    int unsigned                mismatch_cnt = 0;
    int unsigned                burst_left = 0;

    logic [WIN_W-1:0]           win_reg;
    logic signed [SAMPLE_W-1:0] ring_mem[MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] sorted_mem[MAX_WINDOW];
    int unsigned                fill_cnt;
    int unsigned                ring_ptr;

    sliding_window_median_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int unsigned window_len();
        int unsigned w;
        w = win_reg;
        if (w < 1)
        begin
            w = 1;
        end
        if (w > MAX_WINDOW)
        begin
            w = MAX_WINDOW;
        end
        return w;
    endfunction

    // Updates the predicted window with one sample and returns 1 when the
    // window is full, giving twice its median.
    function automatic bit median_predict(input logic signed [SAMPLE_W-1:0] x,
                                          input logic start,
                                          output logic signed [MEDIAN_W-1:0] med);
        int unsigned w;
        int unsigned n;
        int unsigned p;
        bit found;
        logic signed [MEDIAN_W-1:0] lo;
        logic signed [MEDIAN_W-1:0] hi;
        w = window_len();
        med = '0;
        if (start)
        begin
            fill_cnt = 0;
            ring_ptr = 0;
        end
        if (ring_ptr >= w)
        begin
            ring_ptr = 0;
        end
        if (fill_cnt > w)
        begin
            fill_cnt = w;
        end
        n = fill_cnt;
        if (n >= w)
        begin
            found = 1'b0;
            for (p = 0; p < n; p++)
            begin
                if (!found && sorted_mem[p] == ring_mem[ring_ptr])
                begin
                    found = 1'b1;
                end
                if (found && p + 1 < n)
                begin
                    sorted_mem[p] = sorted_mem[p + 1];
                end
            end
            n = (n > 0) ? n - 1 : 0;
        end
        p = n;
        while (p > 0 && sorted_mem[p - 1] > x)
        begin
            sorted_mem[p] = sorted_mem[p - 1];
            p--;
        end
        sorted_mem[p] = x;
        fill_cnt = n + 1;
        ring_mem[ring_ptr] = x;
        ring_ptr++;
        if (ring_ptr >= w)
        begin
            ring_ptr = 0;
        end
        if (fill_cnt < w)
        begin
            return 1'b0;
        end
        if (w % 2 == 1)
        begin
            lo = sorted_mem[w / 2];
            hi = sorted_mem[w / 2];
        end
        else
        begin
            lo = sorted_mem[w / 2 - 1];
            hi = sorted_mem[w / 2];
        end
        med = lo + hi;
        return 1'b1;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        logic [SAMPLE_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom;
            5, 6, 7:       v = SAMPLE_W'($signed($urandom_range(0, 8)) - 4);
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h7FFF_FFFF;
                    1:       v = 32'h8000_0000;
                    2:       v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    v = 32'h7FFF_FFFF - $urandom_range(0, 3);
                end
                else
                begin
                    v = 32'h8000_0000 + $urandom_range(0, 3);
                end
            end
        endcase
        return v;
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic start);
        logic signed [MEDIAN_W-1:0] med;
        int unsigned gap;
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= start;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        if (median_predict($signed(smp), start, med))
        begin
            median_q = {median_q, med};
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (median_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] size);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
        win_reg  = size;
        fill_cnt = 0;
        ring_ptr = 0;
    endtask

    task automatic test_default_window();
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h0000_0005, 1'b0);
    endtask

    task automatic test_start_request();
        send_sample(32'h0000_0010, 1'b1);
        send_sample(32'h0000_0020, 1'b0);
        send_sample(32'hFFFF_FFF0, 1'b1);
        send_sample(32'hFFFF_FFF0, 1'b1);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'h0000_0002, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
    endtask

    task automatic test_window_extremes();
        set_window(7'd0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h1234_5678, 1'b0);
        set_window(7'd2);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h0000_0003, 1'b0);
        send_sample(32'hFFFF_FFFC, 1'b0);
    endtask

    task automatic run_random_phase(input logic [WIN_W-1:0] size, input int unsigned count,
                                    input bit with_starts);
        logic start;
        set_window(size);
        for (int unsigned i = 0; i < count; i++)
        begin
            start = with_starts && ($urandom_range(0, 29) == 0);
            send_sample(random_sample(), start);
            if (i == count / 2 && $urandom_range(0, 2) == 0)
            begin
                wait_drained();
            end
        end
    endtask

    task automatic test_random_windows();
        run_random_phase(7'd64, 80, 1'b0);
        run_random_phase(7'd127, 80, 1'b0);
        run_random_phase(7'd65, 80, 1'b0);
        run_random_phase(7'd1, 30, 1'b1);
        for (int k = 0; k < 9; k++)
        begin
            if (k == 4)
            begin
                run_random_phase(WIN_W'($urandom_range(21, 63)), 60, 1'b0);
            end
            else
            begin
                run_random_phase(WIN_W'($urandom_range(0, 20)), 40, 1'b1);
            end
        end
    endtask

    task automatic test_drain_pause();
        for (int unsigned i = 0; i < 20; i++)
        begin
            send_sample(random_sample(), 1'b0);
        end
        wait_drained();
        send_sample(random_sample(), 1'b1);
        for (int unsigned i = 0; i < 19; i++)
        begin
            send_sample(random_sample(), 1'b0);
        end
    endtask

    initial
    begin
        ready_mode_t mode;
        int unsigned span;
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 2));
            span = $urandom_range(30, 200);
            repeat (span)
            begin
                @(posedge clk);
                case (mode)
                    RDY_ALWAYS: m_axis_tready <= 1'b1;
                    RDY_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        logic signed [MEDIAN_W-1:0] expected;
        logic [OUT_TDATA_W-1:0]     expected_word;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (median_q.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                begin
                    $display("Unexpected result beat: actual %0d",
                             $signed(m_axis_tdata[MEDIAN_W-1:0]));
                end
            end
            else
            begin
                expected = median_q.pop_front();
                expected_word = '0;
                expected_word[MEDIAN_W-1:0] = expected;
                if (m_axis_tdata !== expected_word)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("Median mismatch: expected %0d actual %0d (tdata %h)",
                                 expected, $signed(m_axis_tdata[MEDIAN_W-1:0]),
                                 m_axis_tdata);
                    end
                end
            end
        end
    end

    initial
    begin
        win_reg  = WINDOW_RESET;
        fill_cnt = 0;
        ring_ptr = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_window();
        test_start_request();
        test_window_extremes();
        test_random_windows();
        set_window(7'd5);
        test_drain_pause();
        wait_drained();
        repeat (20) @(posedge clk);
        if (mismatch_cnt == 0 && median_q.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/swm_pkg.sv
sv/swm_cell.sv
sv/sliding_window_median_unit.sv
bench/sliding_window_median_unit_tb.sv
